[rtl/core/ipp_pkg.sv]
// Shared types and constants for the IP address text parser.
// Holds the end-of-address record passed from the front part to the back part.
// No dependencies.
`timescale 1ns / 1ps

package ipp_pkg;

	localparam int NumGroups = 8;
	localparam int NumOctets = 4;

	localparam logic [1:0] FAM_IPV4 = 2'd0;
	localparam logic [1:0] FAM_IPV6 = 2'd1;

	localparam logic [1:0] STATUS_INVALID     = 2'd0;
	localparam logic [1:0] STATUS_OK          = 2'd1;
	localparam logic [1:0] STATUS_UNSUPPORTED = 2'd2;

	localparam logic [7:0] CH_NUL = 8'h00;

	typedef logic [15:0] group_t;
	typedef logic [7:0]  octet_t;

	// Parse state captured on the NUL item, before the gap is widened
	typedef struct packed {
		logic [1:0]                 family;
		logic                       err;
		logic                       gap;
		logic [2:0]                 gap_idx;
		logic [3:0]                 group_cnt;
		group_t [NumGroups-1:0]     groups;
		octet_t [NumOctets-1:0]     octets;
	} end_rec_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

endpackage

[rtl/core/ipp_front.sv]
// Front part of the address parser: takes one character per item and updates
// the IPv4 / IPv6 parse state; on NUL it emits an end record and clears state.
// Depends on ipp_pkg.
`timescale 1ns / 1ps

module ipp_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       character,
	input  logic [1:0]       family,
	input  logic             queue_full,
	output logic             push,
	output ipp_pkg::end_rec_t rec
);
	import ipp_pkg::*;

	typedef enum logic [3:0] {
		PH_TOP   = 4'b0001,
		PH_GROUP = 4'b0010,
		PH_COLON = 4'b0100,
		PH_QUAD  = 4'b1000
	} phase_t;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [4:0] NO_HEX   = 5'd16;

	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [4:0] v;
		v = NO_HEX;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			v = {1'b0, c[3:0]};
		end else if ((c >= CH_LA && c <= CH_LF) || (c >= CH_UA && c <= CH_UF)) begin
			v = 5'({1'b0, c[3:0]} + 5'd9);
		end
		return v;
	endfunction

	logic                    started_q, n_started;
	logic [1:0]              fam_q;
	logic                    err_q, n_err;
	phase_t                  phase_q, n_phase;
	group_t [NumGroups-1:0]  groups_q, n_groups;
	logic [3:0]              gc_q, n_gc;
	logic                    gap_q, n_gap;
	logic [2:0]              gidx_q, n_gidx;
	logic [15:0]             hex_q, n_hex;
	logic [2:0]              dcnt_q, n_dcnt;
	logic [7:0]              dec_q, n_dec;
	logic                    sad_q, n_sad;
	octet_t [NumOctets-1:0]  oct_q, n_oct;
	logic [2:0]              ocnt_q, n_ocnt;

	logic        accept, is_nul, is_dig, run_top, run_quad;
	logic [4:0]  hv;
	logic [7:0]  digit;
	logic [11:0] dec_t;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;
	assign is_nul   = (character == CH_NUL);
	assign push     = accept && is_nul;
	assign is_dig   = (character >= CH_ZERO) && (character <= CH_NINE);
	assign hv       = hex_val(character);
	assign digit    = character - CH_ZERO;
	assign dec_t    = 12'({dec_q, 3'b000}) + 12'({dec_q, 1'b0}) + 12'(digit);

	always_comb begin
		n_started = 1'b1;
		n_phase   = phase_q;
		n_groups  = groups_q;
		n_gc      = gc_q;
		n_gap     = gap_q;
		n_gidx    = gidx_q;
		n_hex     = hex_q;
		n_dcnt    = dcnt_q;
		n_dec     = dec_q;
		n_sad     = sad_q;
		n_oct     = oct_q;
		n_ocnt    = ocnt_q;
		run_top   = 1'b0;
		run_quad  = 1'b0;
		// a family change inside one address spoils it
		n_err     = err_q || (started_q && family != fam_q);

		if (!n_err) begin
			if (family == FAM_IPV4) begin
				run_quad = 1'b1;
			end else if (family == FAM_IPV6) begin
				case (phase_q)
					PH_TOP: begin
						if (!started_q && character == CH_COLON) begin
							n_phase = PH_COLON;
						end else begin
							run_top = 1'b1;
						end
					end
					PH_COLON: begin
						if (!gap_q) begin
							if (character == CH_COLON) begin
								n_gap   = 1'b1;
								n_gidx  = '0;
								n_phase = PH_TOP;
							end else begin
								n_err = 1'b1;
							end
						end else if (character == CH_COLON) begin
							// colon right after a gap is swallowed
							n_phase = PH_TOP;
						end else begin
							run_top = 1'b1;
						end
					end
					PH_GROUP: begin
						if (hv != NO_HEX) begin
							if (dcnt_q >= 3'd4) begin
								n_err = 1'b1;
							end else begin
								n_dcnt = dcnt_q + 3'd1;
								n_hex  = {hex_q[11:0], hv[3:0]};
								if (sad_q) begin
									if (!is_dig || dec_t > 12'd255) begin
										n_sad = 1'b0;
									end else begin
										n_dec = dec_t[7:0];
									end
								end
							end
						end else if (character == CH_DOT) begin
							if (gc_q > 4'd6 || !sad_q) begin
								n_err = 1'b1;
							end else begin
								n_oct[0] = dec_q;
								n_ocnt   = 3'd1;
								n_dec    = '0;
								n_dcnt   = '0;
								n_phase  = PH_QUAD;
							end
						end else if (character == CH_COLON || is_nul) begin
							n_groups[gc_q[2:0]] = hex_q;
							n_gc                = gc_q + 4'd1;
							if (!is_nul) begin
								n_phase = PH_TOP;
							end
						end else begin
							n_err = 1'b1;
						end
					end
					PH_QUAD: begin
						run_quad = 1'b1;
					end
					default: begin
						n_err = 1'b1;
					end
				endcase
			end
		end

		// first character of a group
		if (run_top && !is_nul) begin
			if (gc_q >= 4'd8) begin
				n_err = 1'b1;
			end else if (character == CH_COLON) begin
				if (gap_q) begin
					n_err = 1'b1;
				end else begin
					n_gap   = 1'b1;
					n_gidx  = gc_q[2:0];
					n_phase = PH_COLON;
				end
			end else if (hv == NO_HEX) begin
				n_err = 1'b1;
			end else begin
				n_hex   = 16'(hv[3:0]);
				n_dcnt  = 3'd1;
				n_sad   = is_dig;
				n_dec   = is_dig ? digit : 8'd0;
				n_phase = PH_GROUP;
			end
		end

		// dotted quad: plain IPv4 or the IPv6 tail
		if (run_quad) begin
			if (is_dig) begin
				if (dec_t > 12'd255) begin
					n_err = 1'b1;
				end else begin
					n_dec  = dec_t[7:0];
					n_dcnt = 3'd1;
				end
			end else if (character == CH_DOT || is_nul) begin
				if (dcnt_q == 3'd0 || ocnt_q >= 3'd4) begin
					n_err = 1'b1;
				end else begin
					n_oct[ocnt_q[1:0]] = dec_q;
					n_ocnt             = ocnt_q + 3'd1;
					n_dec              = '0;
					n_dcnt             = '0;
					if (is_nul && n_ocnt != 3'd4) begin
						n_err = 1'b1;
					end
				end
			end else begin
				n_err = 1'b1;
			end
			if (family == FAM_IPV6 && is_nul && !n_err) begin
				if (gc_q > 4'd6) begin
					n_err = 1'b1;
				end else begin
					n_groups[gc_q[2:0]]             = {n_oct[0], n_oct[1]};
					n_groups[3'(gc_q[2:0] + 3'd1)] = {n_oct[2], n_oct[3]};
					n_gc                            = gc_q + 4'd2;
				end
			end
		end
	end

	always_comb begin
		rec.family    = family;
		rec.err       = n_err;
		rec.gap       = n_gap;
		rec.gap_idx   = n_gidx;
		rec.group_cnt = n_gc;
		rec.groups    = n_groups;
		rec.octets    = n_oct;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			fam_q     <= '0;
			err_q     <= 1'b0;
			phase_q   <= PH_TOP;
			groups_q  <= '0;
			gc_q      <= '0;
			gap_q     <= 1'b0;
			gidx_q    <= '0;
			hex_q     <= '0;
			dcnt_q    <= '0;
			dec_q     <= '0;
			sad_q     <= 1'b1;
			oct_q     <= '0;
			ocnt_q    <= '0;
		end else if (accept) begin
			if (is_nul) begin
				// address done: back to the start state
				started_q <= 1'b0;
				fam_q     <= '0;
				err_q     <= 1'b0;
				phase_q   <= PH_TOP;
				groups_q  <= '0;
				gc_q      <= '0;
				gap_q     <= 1'b0;
				gidx_q    <= '0;
				hex_q     <= '0;
				dcnt_q    <= '0;
				dec_q     <= '0;
				sad_q     <= 1'b1;
				oct_q     <= '0;
				ocnt_q    <= '0;
			end else begin
				if (!started_q) begin
					fam_q <= family;
				end
				started_q <= n_started;
				err_q     <= n_err;
				phase_q   <= n_phase;
				groups_q  <= n_groups;
				gc_q      <= n_gc;
				gap_q     <= n_gap;
				gidx_q    <= n_gidx;
				hex_q     <= n_hex;
				dcnt_q    <= n_dcnt;
				dec_q     <= n_dec;
				sad_q     <= n_sad;
				oct_q     <= n_oct;
				ocnt_q    <= n_ocnt;
			end
		end
	end

endmodule

[rtl/core/ipp_queue.sv]
// Small FIFO of end records between the parser front and the result stage.
// Depends on ipp_pkg.
`timescale 1ns / 1ps

module ipp_queue #(
	parameter int DEPTH = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  ipp_pkg::end_rec_t    wr_rec,
	input  logic                 pop,
	output ipp_pkg::end_rec_t    rd_rec,
	output ipp_pkg::queue_stat_t stat
);
	import ipp_pkg::*;

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	end_rec_t            mem_q [DEPTH];
	logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0]     count_q;
	logic                do_push, do_pop;

	assign stat.full  = (count_q == CntW'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign rd_rec     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CntW'(1);
				2'b01:   count_q <= count_q - CntW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[rtl/core/ipp_back.sv]
// Result stage: widens the IPv6 "::" gap, checks the group count, and
// registers status and address for the output channel.
// Depends on ipp_pkg.
`timescale 1ns / 1ps

module ipp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  ipp_pkg::end_rec_t rec,
	input  logic              rec_valid,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        status,
	output logic [63:0]       address_high,
	output logic [63:0]       address_low
);
	import ipp_pkg::*;

	logic                   out_valid_q;
	logic [1:0]             status_q;
	logic [63:0]            hi_q, lo_q;

	logic [3:0]             zeros, gap_end;
	logic [3:0]             src_idx [NumGroups];
	group_t [NumGroups-1:0] exp_groups;
	logic                   v6_bad;
	logic [1:0]             n_status;
	logic [63:0]            n_hi, n_lo;

	assign pop = rec_valid && (!out_valid_q || out_ready);

	always_comb begin
		zeros   = 4'd8 - rec.group_cnt;
		gap_end = {1'b0, rec.gap_idx} + zeros;
		for (int i = 0; i < NumGroups; i++) begin
			src_idx[i] = 4'(i) - zeros;
			if (!rec.gap || 4'(i) < {1'b0, rec.gap_idx}) begin
				exp_groups[i] = rec.groups[i];
			end else if (4'(i) < gap_end) begin
				exp_groups[i] = '0;
			end else begin
				exp_groups[i] = rec.groups[src_idx[i][2:0]];
			end
		end
		v6_bad = rec.err || (rec.gap ? (rec.group_cnt >= 4'd8) : (rec.group_cnt != 4'd8));

		n_status = STATUS_INVALID;
		n_hi     = '0;
		n_lo     = '0;
		if (rec.family == FAM_IPV4) begin
			if (!rec.err) begin
				n_status = STATUS_OK;
				n_lo = {32'd0, rec.octets[0], rec.octets[1], rec.octets[2], rec.octets[3]};
			end
		end else if (rec.family == FAM_IPV6) begin
			if (!v6_bad) begin
				n_status = STATUS_OK;
				n_hi = {exp_groups[0], exp_groups[1], exp_groups[2], exp_groups[3]};
				n_lo = {exp_groups[4], exp_groups[5], exp_groups[6], exp_groups[7]};
			end
		end else begin
			n_status = STATUS_UNSUPPORTED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			status_q <= n_status;
			hi_q     <= n_hi;
			lo_q     <= n_lo;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign address_high = hi_q;
	assign address_low  = lo_q;

endmodule

[rtl/core/ip_address_text_parser.sv]
// IP address text parser, one character per item, result on the NUL item.
// Throughput: one character per cycle, NULs included, while the record queue has room.
// The NUL's record passes through the queue, then the result register, to the output.
// Up to QUEUE_DEPTH finished addresses wait in the queue while the output stalls.
// Reset: arst_n clears the parse state, queue and output valid; no clearing pass.
`timescale 1ns / 1ps

module ip_address_text_parser #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  character,
	input  logic [1:0]  family,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [63:0] address_high,
	output logic [63:0] address_low
);
	import ipp_pkg::*;

	end_rec_t    wr_rec, rd_rec;
	queue_stat_t qstat;
	logic        push, pop;

	ipp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.character  (character),
		.family     (family),
		.queue_full (qstat.full),
		.push       (push),
		.rec        (wr_rec)
	);

	ipp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_rec (wr_rec),
		.pop    (pop),
		.rd_rec (rd_rec),
		.stat   (qstat)
	);

	ipp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.rec          (rd_rec),
		.rec_valid    (!qstat.empty),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.address_high (address_high),
		.address_low  (address_low)
	);

`ifndef NO_ASSERTIONS
	a_bad_status_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STATUS_OK |-> address_high == '0 && address_low == '0)
		else $error("non-ok result carries a nonzero address");

	a_nul_reaches_queue: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && character == CH_NUL |=> !qstat.empty)
		else $error("accepted NUL item left no record in the queue");

	a_full_stalls_input: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.full |-> !in_ready)
		else $error("input taken while the record queue is full");
`endif

endmodule
